### design/mwuf_pkg.sv
// Shared types and fixed field widths of the maze wall union-find unit.
`default_nettype none
package mwuf_pkg;

  localparam int unsigned WallW    = 12;
  localparam int unsigned GridW    = 6;
  localparam int unsigned CellOutW = 11;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_LAUNCH,
    ST_FIND,
    ST_UNION_A,
    ST_UNION_B
  } state_e;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_START,
    PH_END
  } phase_e;

endpackage
`default_nettype wire

### design/maze_wall_union_find_unit.sv
// Top level of the maze wall union-find unit: control, finds and unions.
// After reset the unit sweeps all 2*MAX_SIDE*MAX_SIDE+2*MAX_SIDE wall slots
// (2112 at the default) with busy high. Each wall index then passes
// through the shift-subtract divider and a decode state. An invalid wall
// runs two finds and a valid wall four, each following parent links hop
// by hop. A union, run when the two roots differ, removes the wall in
// states UNION_A and UNION_B. Union by rank bounds each find at
// log2(MAX_SIDE*MAX_SIDE) hops (10 at the default). The result appears on
// done_o for one cycle and cannot be held off; start is taken again from
// that cycle on.
`default_nettype none
module maze_wall_union_find_unit #(
  parameter int unsigned MAX_SIDE = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          grid_side_we_i,
  input  wire logic [mwuf_pkg::GridW-1:0]    grid_side_i,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [mwuf_pkg::WallW-1:0]    wall_index_i,
  output logic                               done_o,
  output logic                               wall_valid_o,
  output logic                               wall_removed_o,
  output logic [mwuf_pkg::CellOutW-1:0]      first_cell_o,
  output logic [mwuf_pkg::CellOutW-1:0]      second_cell_o,
  output logic                               start_end_joined_o
);

  localparam int unsigned MaxCells  = MAX_SIDE * MAX_SIDE;
  localparam int unsigned MaxWalls  = 2 * MaxCells + 2 * MAX_SIDE;
  localparam int unsigned CellW     = $clog2(MaxCells + 1);
  localparam int unsigned AddrW     = $clog2(MaxCells);
  localparam int unsigned LinkW     = CellW + 1;
  localparam int unsigned SideW     = $clog2(MAX_SIDE + 1);
  localparam int unsigned StrideW   = $clog2(2 * MAX_SIDE + 2);
  localparam int unsigned WallAddrW = $clog2(MaxWalls);

  mwuf_pkg::state_e state_q, state_d;
  mwuf_pkg::phase_e phase_q;

  logic [mwuf_pkg::GridW-1:0] grid_q;
  logic [WallAddrW-1:0]       clr_q;
  logic [mwuf_pkg::WallW-1:0] wall_q;
  logic [SideW-1:0]           n_q, n_clamp;
  logic [CellW-1:0]           nn_q, c1_q, c2_q, cur_q, r1_q, r2_q, ra_q, start_cell;
  logic signed [LinkW-1:0]    rank1_q, rank2_q, link;
  logic                       valid_q, removed_q, joined_q, done_q;

  logic                       div_start, div_done;
  logic [mwuf_pkg::WallW-1:0] row;
  logic [StrideW-1:0]         off, stride;

  logic                       link_we, wall_we, wall_wdata;
  logic [AddrW-1:0]           link_waddr, link_raddr;
  logic [LinkW-1:0]           link_wdata, link_rdata;
  logic [WallAddrW-1:0]       wall_waddr;

  logic                       dec_valid;
  logic [SideW-1:0]           row_s;
  logic [2*SideW-1:0]         prod, nsq;
  logic [CellW-1:0]           c1_calc, c2_calc;
  logic                       root_found, rank_lt;

  // Side in use, clamped to the supported range
  always_comb begin
    if (grid_q < mwuf_pkg::GridW'(2)) begin
      n_clamp = SideW'(2);
    end else if (int'(grid_q) > int'(MAX_SIDE)) begin
      n_clamp = SideW'(MAX_SIDE);
    end else begin
      n_clamp = SideW'(grid_q);
    end
  end

  assign stride    = StrideW'({n_q, 1'b1});
  assign div_start = (state_q == mwuf_pkg::ST_IDLE) && start;

  mwuf_divider #(
    .DivW (StrideW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (wall_index_i),
    .divisor_i  (stride),
    .done_o     (div_done),
    .quot_o     (row),
    .rem_o      (off)
  );

  // Decode the slot into its two cells
  always_comb begin
    dec_valid = (wall_q >= mwuf_pkg::WallW'(n_q)) &&
                (off != StrideW'(n_q)) &&
                (off != StrideW'({n_q, 1'b0})) &&
                (row < mwuf_pkg::WallW'(n_q));
    row_s     = SideW'(row);
    prod      = row_s * n_q;
    nsq       = n_q * n_q;
    if (off > StrideW'(n_q)) begin
      c1_calc = CellW'(prod) + CellW'(off) - CellW'(n_q);
      c2_calc = c1_calc + CellW'(1);
    end else begin
      c1_calc = CellW'(prod) - CellW'(n_q) + CellW'(off) + CellW'(1);
      c2_calc = c1_calc + CellW'(n_q);
    end
  end

  always_comb begin
    unique case (phase_q)
      mwuf_pkg::PH_FIRST:  start_cell = c1_q;
      mwuf_pkg::PH_SECOND: start_cell = c2_q;
      mwuf_pkg::PH_START:  start_cell = CellW'(1);
      mwuf_pkg::PH_END:    start_cell = nn_q;
      default:             start_cell = nn_q;
    endcase
  end

  assign link       = $signed(link_rdata);
  assign root_found = !(link > 0);
  assign rank_lt    = (rank2_q < rank1_q);

  // Next state and memory controls
  always_comb begin
    state_d    = state_q;
    link_we    = 1'b0;
    link_waddr = '0;
    link_wdata = '0;
    link_raddr = '0;
    wall_we    = 1'b0;
    wall_waddr = '0;
    wall_wdata = 1'b0;
    unique case (state_q)
      mwuf_pkg::ST_CLEAR: begin
        wall_we    = 1'b1;
        wall_waddr = clr_q;
        wall_wdata = 1'b1;
        link_we    = ({1'b0, clr_q} < (WallAddrW + 1)'(MaxCells));
        link_waddr = AddrW'(clr_q);
        if (clr_q == WallAddrW'(MaxWalls - 1)) begin
          state_d = mwuf_pkg::ST_IDLE;
        end
      end
      mwuf_pkg::ST_IDLE: begin
        if (start) begin
          state_d = mwuf_pkg::ST_DIV;
        end
      end
      mwuf_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = mwuf_pkg::ST_CHECK;
        end
      end
      mwuf_pkg::ST_CHECK: begin
        state_d = mwuf_pkg::ST_LAUNCH;
      end
      mwuf_pkg::ST_LAUNCH: begin
        link_raddr = AddrW'(start_cell - CellW'(1));
        state_d    = mwuf_pkg::ST_FIND;
      end
      mwuf_pkg::ST_FIND: begin
        if (!root_found) begin
          // follow the parent link straight away
          link_raddr = AddrW'(link[CellW-1:0] - CellW'(1));
        end else begin
          priority if (phase_q == mwuf_pkg::PH_SECOND && r1_q != cur_q) begin
            state_d = mwuf_pkg::ST_UNION_A;
          end else if (phase_q == mwuf_pkg::PH_END) begin
            state_d = mwuf_pkg::ST_IDLE;
          end else begin
            state_d = mwuf_pkg::ST_LAUNCH;
          end
        end
      end
      mwuf_pkg::ST_UNION_A: begin
        wall_we    = 1'b1;
        wall_waddr = WallAddrW'(wall_q);
        link_waddr = AddrW'(r1_q - CellW'(1));
        if (rank_lt) begin
          link_we    = 1'b1;
          link_wdata = {1'b0, r2_q};
        end else if (rank1_q == rank2_q) begin
          link_we    = 1'b1;
          link_wdata = rank1_q - LinkW'(1);
        end
        state_d = mwuf_pkg::ST_UNION_B;
      end
      mwuf_pkg::ST_UNION_B: begin
        link_we    = !rank_lt;
        link_waddr = AddrW'(r2_q - CellW'(1));
        link_wdata = {1'b0, r1_q};
        state_d    = mwuf_pkg::ST_LAUNCH;
      end
      default: state_d = mwuf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mwuf_pkg::ST_CLEAR;
      grid_q  <= mwuf_pkg::GridW'(8);
      clr_q   <= '0;
      phase_q <= mwuf_pkg::PH_FIRST;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == mwuf_pkg::ST_FIND) && root_found &&
                 (phase_q == mwuf_pkg::PH_END);
      if (grid_side_we_i) begin
        grid_q <= grid_side_i;
      end
      if (state_q == mwuf_pkg::ST_CLEAR) begin
        clr_q <= clr_q + WallAddrW'(1);
      end
      if (state_q == mwuf_pkg::ST_CHECK) begin
        phase_q <= dec_valid ? mwuf_pkg::PH_FIRST : mwuf_pkg::PH_START;
      end
      if (state_q == mwuf_pkg::ST_UNION_B) begin
        phase_q <= mwuf_pkg::PH_START;
      end
      if (state_q == mwuf_pkg::ST_FIND && root_found) begin
        unique case (phase_q)
          mwuf_pkg::PH_FIRST:  phase_q <= mwuf_pkg::PH_SECOND;
          mwuf_pkg::PH_SECOND: phase_q <= mwuf_pkg::PH_START;
          mwuf_pkg::PH_START:  phase_q <= mwuf_pkg::PH_END;
          mwuf_pkg::PH_END:    phase_q <= mwuf_pkg::PH_FIRST;
          default:             phase_q <= mwuf_pkg::PH_END;
        endcase
      end
    end
  end

  // Item payload and find results
  always_ff @(posedge clk_i) begin
    if (state_q == mwuf_pkg::ST_IDLE && start) begin
      wall_q    <= wall_index_i;
      n_q       <= n_clamp;
      removed_q <= 1'b0;
    end
    if (state_q == mwuf_pkg::ST_CHECK) begin
      valid_q <= dec_valid;
      nn_q    <= CellW'(nsq);
      c1_q    <= dec_valid ? c1_calc : '0;
      c2_q    <= dec_valid ? c2_calc : '0;
    end
    if (state_q == mwuf_pkg::ST_LAUNCH) begin
      cur_q <= start_cell;
    end
    if (state_q == mwuf_pkg::ST_FIND) begin
      if (!root_found) begin
        cur_q <= link[CellW-1:0];
      end else begin
        unique case (phase_q)
          mwuf_pkg::PH_FIRST: begin
            r1_q    <= cur_q;
            rank1_q <= link;
          end
          mwuf_pkg::PH_SECOND: begin
            r2_q    <= cur_q;
            rank2_q <= link;
          end
          mwuf_pkg::PH_START: ra_q     <= cur_q;
          mwuf_pkg::PH_END:   joined_q <= (ra_q == cur_q);
          default:            ra_q     <= cur_q;
        endcase
      end
    end
    if (state_q == mwuf_pkg::ST_UNION_A) begin
      removed_q <= 1'b1;
    end
  end

  mwuf_link_ram #(
    .Depth (MaxCells),
    .DataW (LinkW)
  ) u_links (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  mwuf_wall_ram #(
    .Depth (MaxWalls)
  ) u_walls (
    .clk_i   (clk_i),
    .we_i    (wall_we),
    .waddr_i (wall_waddr),
    .wdata_i (wall_wdata)
  );

  assign busy               = (state_q != mwuf_pkg::ST_IDLE);
  assign done_o             = done_q;
  assign wall_valid_o       = valid_q;
  assign wall_removed_o     = removed_q;
  assign first_cell_o       = mwuf_pkg::CellOutW'(c1_q);
  assign second_cell_o      = mwuf_pkg::CellOutW'(c2_q);
  assign start_end_joined_o = joined_q;

`ifndef SYNTHESIS
  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result beat lasted more than one cycle");

  a_removed_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && wall_removed_o |-> wall_valid_o) else $error("wall removed but not valid");

  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !wall_valid_o |-> first_cell_o == '0 && second_cell_o == '0)
    else $error("invalid wall reported cells");

  a_idle_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mwuf_pkg::ST_IDLE |-> !link_we && !wall_we)
    else $error("store written while idle");
`endif

endmodule
`default_nettype wire

### design/mwuf_divider.sv
// Restoring divider: one quotient bit per cycle, wall slot by row stride.
`default_nettype none
module mwuf_divider #(
  parameter int unsigned DivW = 7
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [mwuf_pkg::WallW-1:0] dividend_i,
  input  wire logic [DivW-1:0]            divisor_i,
  output logic                            done_o,
  output logic [mwuf_pkg::WallW-1:0]      quot_o,
  output logic [DivW-1:0]                 rem_o
);

  localparam int unsigned CntW = $clog2(mwuf_pkg::WallW);

  logic                       run_q, run_d;
  logic                       done_q, done_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [mwuf_pkg::WallW-1:0] quot_q, quot_d;
  logic [DivW-1:0]            rem_q, rem_d;
  logic [DivW:0]              trial;
  logic                       fits;

  always_comb begin
    trial  = {rem_q, quot_q[mwuf_pkg::WallW-1]};
    fits   = (trial >= {1'b0, divisor_i});
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
    end else if (run_q) begin
      rem_d  = fits ? DivW'(trial - {1'b0, divisor_i}) : DivW'(trial);
      quot_d = {quot_q[mwuf_pkg::WallW-2:0], fits};
      cnt_d  = cnt_q + CntW'(1);
      if (cnt_q == CntW'(mwuf_pkg::WallW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

### design/mwuf_link_ram.sv
// Set link memory: parent cell or negated root rank, one read and one write port.
`default_nettype none
module mwuf_link_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned DataW = 12
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [DataW-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataW-1:0]              rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### design/mwuf_wall_ram.sv
// Wall presence bits, one per wall slot.
`default_nettype none
module mwuf_wall_ram #(
  parameter int unsigned Depth = 2112
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic                     wdata_i
);

  logic mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

endmodule
`default_nettype wire
